>>> rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
// No dependencies; used by wsfd_parser and websocket_frame_decoder.
package wsfd_pkg;

	// Seven-bit length codes that announce an extended length field
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// Extended-length and mask-key byte counts, minus one
	localparam logic [2:0] EXT16_CNT = 3'd1;
	localparam logic [2:0] EXT64_CNT = 3'd7;
	localparam logic [2:0] KEY_CNT   = 3'd3;

	localparam logic [3:0] OPC_CLOSE = 4'h8;

	// One result of the parser, before the output register
	typedef struct packed {
		logic       fire;
		logic [7:0] data;
		logic       has;
		logic       last;
		logic       cls;
		logic [3:0] opcode;
	} wsfd_res_t;

endpackage

>>> rtl/wsfd_parser.sv
// Frame header/payload state machine of the WebSocket frame decoder.
// Depends on wsfd_pkg; produces at most one result per accepted byte.
module wsfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	output wsfd_pkg::wsfd_res_t res
);
	import wsfd_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_MASKKEY,
		PH_PAYLOAD
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  opc_q, opc_d;
	logic        mask_q, mask_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [63:0] rem_q, rem_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  mph_q, mph_d;

	logic        len_done;
	logic [63:0] len_val;
	logic        start_pl;
	logic [63:0] rem_dec;
	logic [7:0]  key_byte;

	assign rem_dec = rem_q - 64'd1;

	always_comb begin
		unique case (mph_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		opc_d    = opc_q;
		mask_d   = mask_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		key_d    = key_q;
		mph_d    = mph_q;
		len_done = 1'b0;
		len_val  = rem_q;
		start_pl = 1'b0;
		res      = '0;

		unique case (phase_q)
			PH_HDR1: begin
				mask_d = rx_byte[7];
				if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
					rem_d   = '0;
					cnt_d   = (rx_byte[6:0] == LEN_EXT16) ? EXT16_CNT : EXT64_CNT;
					phase_d = PH_EXTLEN;
				end else begin
					len_done = 1'b1;
					len_val  = {57'd0, rx_byte[6:0]};
				end
			end
			PH_EXTLEN: begin
				rem_d = {rem_q[55:0], rx_byte};
				if (cnt_q == '0) begin
					len_done = 1'b1;
					len_val  = {rem_q[55:0], rx_byte};
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			PH_MASKKEY: begin
				key_d = {key_q[23:0], rx_byte};
				if (cnt_q == '0) begin
					start_pl = 1'b1;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			PH_PAYLOAD: begin
				mph_d = mph_q + 2'd1;
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_HDR0;
				end
				if (opc_q == OPC_CLOSE) begin
					// suppress close payload, flag only its end
					res.fire = (rem_dec == '0);
					res.last = 1'b1;
					res.cls  = 1'b1;
				end else begin
					res.fire = 1'b1;
					res.has  = 1'b1;
					res.data = mask_q ? (rx_byte ^ key_byte) : rx_byte;
					res.last = (rem_dec == '0);
				end
			end
			default: begin
				opc_d   = rx_byte[3:0];
				phase_d = PH_HDR1;
			end
		endcase

		// length known: go to mask key or straight to payload
		if (len_done) begin
			rem_d = len_val;
			if (mask_d) begin
				key_d   = '0;
				cnt_d   = KEY_CNT;
				phase_d = PH_MASKKEY;
			end else begin
				start_pl = 1'b1;
			end
		end

		// header complete: empty frame ends at once
		if (start_pl) begin
			mph_d = '0;
			if (rem_d == '0) begin
				phase_d  = PH_HDR0;
				res.fire = 1'b1;
				res.last = 1'b1;
				res.cls  = (opc_q == OPC_CLOSE);
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end

		res.opcode = opc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			opc_q   <= '0;
			mask_q  <= 1'b0;
			cnt_q   <= '0;
			rem_q   <= '0;
			key_q   <= '0;
			mph_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			opc_q   <= opc_d;
			mask_q  <= mask_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			key_q   <= key_d;
			mph_q   <= mph_d;
		end
	end

endmodule

>>> rtl/websocket_frame_decoder.sv
// WebSocket frame decoder: one received byte per request, payload bytes out.
// A result appears on the outputs in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle while rx_stall is low; the parser state updates on each taken byte.
// A full output register that is stalled holds off the next byte.
// Reset (arst_n low, asynchronous): parser awaits a first header byte, no result held.
// Depends on wsfd_pkg and wsfd_parser.
module websocket_frame_decoder (
	input  logic       clk,
	input  logic       arst_n,
	// byte request channel
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	// result request channel
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] data_byte,
	output logic       has_data,
	output logic       frame_end,
	output logic       is_close,
	output logic [3:0] frame_opcode
);
	import wsfd_pkg::*;

	logic      take;
	wsfd_res_t res;
	logic      res_valid_q;
	wsfd_res_t res_q;

	// Hold off input only when a finished result is still waiting
	assign rx_stall = res_valid_q && res_stall;
	assign take     = rx_valid && !rx_stall;

	// Header bytes, payload countdown and unmasking all live here
	wsfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.res     (res)
	);

	// Output register: load a new result, or drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && res.fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload carries no reset
	always_ff @(posedge clk) begin
		if (take && res.fire) begin
			res_q <= res;
		end
	end

	assign res_valid    = res_valid_q;
	assign data_byte    = res_q.data;
	assign has_data     = res_q.has;
	assign frame_end    = res_q.last;
	assign is_close     = res_q.cls;
	assign frame_opcode = res_q.opcode;

`ifndef SYNTHESIS
	// A close result is an end marker with no data, on a close opcode
	a_close_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_close |-> frame_end && !has_data && frame_opcode == OPC_CLOSE)
		else $error("close result malformed");

	// A result without data is always a frame end with a zero byte
	a_nodata_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !has_data |-> frame_end && data_byte == 8'd0)
		else $error("empty result is not a frame end");

	// Input is held off only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> res_valid && res_stall)
		else $error("input stalled without a waiting result");
`endif

endmodule
